>>> design/irmt_pkg.sv
package irmt_pkg;

	localparam int TABLE_ROWS        = 16;
	localparam int IMAGE_BYTES       = 256;
	localparam int DEF_MAP_ENTRIES   = 16;
	localparam int DEF_STORE_BYTES   = 64;
	localparam int DEF_MAX_REG_BYTES = 8;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic STATUS_ACK  = 1'b0;
	localparam logic STATUS_NACK = 1'b1;

	typedef logic [7:0] image_t [IMAGE_BYTES];

	localparam logic [7:0] MapAddr [TABLE_ROWS] = '{
		8'h00, 8'h01, 8'h02, 8'h04, 8'h05, 8'h10, 8'h12, 8'h20,
		8'h30, 8'h40, 8'h41, 8'h50, 8'h60, 8'h70, 8'hF0, 8'hFE
	};

	localparam logic [3:0] MapWidth [TABLE_ROWS] = '{
		4'd1, 4'd1, 4'd2, 4'd1, 4'd6, 4'd2, 4'd2, 4'd4,
		4'd8, 4'd1, 4'd1, 4'd2, 4'd4, 4'd8, 4'd1, 4'd2
	};

	localparam logic MapWritable [TABLE_ROWS] = '{
		1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1,
		1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
	};

	// reset bytes per row, byte 0 in bits 7:0
	localparam logic [63:0] MapInit [TABLE_ROWS] = '{
		64'h0000_0000_0000_005A,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0010,
		64'h0000_0000_0000_0000,
		64'h0000_0605_0403_0201,
		64'h0000_0000_0000_7FFF,
		64'h0000_0000_0000_8000,
		64'h0000_0000_1234_5678,
		64'h8877_6655_4433_2211,
		64'h0000_0000_0000_00A5,
		64'h0000_0000_0000_003C,
		64'h0000_0000_0000_BEEF,
		64'h0000_0000_0000_0000,
		64'hBEBA_FECA_EFBE_ADDE,
		64'h0000_0000_0000_0001,
		64'h0000_0000_0000_5449
	};

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_WR,
		S_RD_ISSUE,
		S_RD_CAPT,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic       hit;
		logic       writable;
		logic [3:0] width;
		logic [7:0] offset;
	} lookup_t;

	typedef struct packed {
		logic req_ready;
		logic look;
		logic wr;
		logic rd_issue;
		logic rd_capt;
		logic done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic req_fire;
		logic go_write;
		logic go_read;
		logic last;
		logic rsp_free;
	} ctrl_stat_t;

	// number of table rows that make it into the map
	function automatic int map_count_f(int entries, int store_bytes, int max_reg);
		int used;
		int cnt;
		int w;
		logic stop;
		used = 0;
		cnt  = 0;
		stop = 1'b0;
		for (int i = 0; i < TABLE_ROWS; i++) begin
			w = int'(MapWidth[i]);
			if (i >= entries || w == 0 || w > max_reg || w > 8 || used + w > store_bytes)
				stop = 1'b1;
			if (!stop) begin
				used = used + w;
				cnt  = i + 1;
			end
		end
		return cnt;
	endfunction

	function automatic int map_offset_f(int row);
		int used;
		used = 0;
		for (int i = 0; i < TABLE_ROWS; i++) begin
			if (i < row)
				used = used + int'(MapWidth[i]);
		end
		return used;
	endfunction

	// store contents after reset; bytes owned by no entry are zero
	function automatic image_t build_image_f(int entries, int store_bytes, int max_reg);
		image_t img;
		int cnt;
		int used;
		cnt  = map_count_f(entries, store_bytes, max_reg);
		used = 0;
		for (int b = 0; b < IMAGE_BYTES; b++)
			img[b] = 8'h00;
		for (int i = 0; i < TABLE_ROWS; i++) begin
			if (i < cnt) begin
				for (int k = 0; k < 8; k++) begin
					if (k < int'(MapWidth[i]))
						img[used + k] = MapInit[i][k*8 +: 8];
				end
				used = used + int'(MapWidth[i]);
			end
		end
		return img;
	endfunction

endpackage

>>> design/irmt_if.sv
interface irmt_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [3:0]  byte_count;
	logic [7:0]  pointer_byte;
	logic [63:0] write_data;
	logic        repeated_start;

	modport source (output valid, output operation, output byte_count, output pointer_byte,
		output write_data, output repeated_start, input ready);
	modport sink (input valid, input operation, input byte_count, input pointer_byte,
		input write_data, input repeated_start, output ready);
endinterface

interface irmt_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [3:0]  read_count;
	logic [63:0] read_data;

	modport source (output valid, output status, output read_count, output read_data,
		input ready);
	modport sink (input valid, input status, input read_count, input read_data,
		output ready);
endinterface

>>> design/irmt_ram.sv
module irmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

>>> design/irmt_lookup.sv
module irmt_lookup #(
	parameter int MAP_ENTRIES   = 16,
	parameter int STORE_BYTES   = 64,
	parameter int MAX_REG_BYTES = 8
) (
	input  logic [7:0]       addr,
	output irmt_pkg::lookup_t result
);
	import irmt_pkg::*;

	localparam int Count = map_count_f(MAP_ENTRIES, STORE_BYTES, MAX_REG_BYTES);

	// first matching entry wins, so scan from the top down
	always_comb begin
		result = '0;
		for (int i = TABLE_ROWS - 1; i >= 0; i--) begin
			if (i < Count && addr == MapAddr[i]) begin
				result.hit      = 1'b1;
				result.writable = MapWritable[i];
				result.width    = MapWidth[i];
				result.offset   = 8'(map_offset_f(i));
			end
		end
	end

endmodule

>>> design/irmt_ctrl.sv
module irmt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  irmt_pkg::ctrl_stat_t stat,
	output irmt_pkg::ctrl_cmd_t  cmd
);
	import irmt_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (stat.req_fire)
					state_d = S_LOOK;
			end
			S_LOOK: begin
				if (stat.go_write)
					state_d = S_WR;
				else if (stat.go_read)
					state_d = S_RD_ISSUE;
				else
					state_d = S_DONE;
			end
			S_WR: begin
				if (stat.last)
					state_d = S_DONE;
			end
			S_RD_ISSUE: begin
				state_d = S_RD_CAPT;
			end
			S_RD_CAPT: begin
				if (stat.last)
					state_d = S_DONE;
				else
					state_d = S_RD_ISSUE;
			end
			S_DONE: begin
				if (stat.rsp_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.req_ready = (state_q == S_IDLE);
		cmd.look      = (state_q == S_LOOK);
		cmd.wr        = (state_q == S_WR);
		cmd.rd_issue  = (state_q == S_RD_ISSUE);
		cmd.rd_capt   = (state_q == S_RD_CAPT);
		cmd.done      = (state_q == S_DONE);
	end

endmodule

>>> design/i2c_register_map_target_core.sv
// channel   dir  payload                                                       
// req       in   operation, byte_count, pointer_byte, write_data, repeated_start
// rsp       out  status, read_count, read_data                                  
// cfg       in   cfg_we, cfg_wdata (require_repeated_start)                     
//
// one transaction at a time; the store is a single-port ram moving one byte per step
// probe, pointer-only or refused write: accept, lookup, done; accepted write adds one store step per data byte
// read: adds an issue step and a capture step per returned byte (ram address then registered data)
// reset loads the map and pointer at once: per-byte valid flops select the reset image
// a waiting response holds in its register; the next request is still taken
module i2c_register_map_target_core #(
	parameter int MAP_ENTRIES   = irmt_pkg::DEF_MAP_ENTRIES,
	parameter int STORE_BYTES   = irmt_pkg::DEF_STORE_BYTES,
	parameter int MAX_REG_BYTES = irmt_pkg::DEF_MAX_REG_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	irmt_req_if.sink   req,
	irmt_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import irmt_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam image_t ResetImg = build_image_f(MAP_ENTRIES, STORE_BYTES, MAX_REG_BYTES);

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;
	lookup_t    lk;

	logic          rrs_q;
	logic [7:0]    cur_ptr_q;
	logic          op_q;
	logic [3:0]    len_q;
	logic [63:0]   wdata_q;
	logic          rs_q;
	logic [7:0]    lk_addr_q;
	logic [AW-1:0] off_q;
	logic [3:0]    n_q;
	logic [3:0]    k_q;
	logic          status_q;
	logic [3:0]    rcount_q;
	logic [63:0]   rdata_q;
	logic          rsp_valid_q;
	logic          rsp_status_q;
	logic [3:0]    rsp_count_q;
	logic [63:0]   rsp_data_q;
	logic          valid_q [STORE_BYTES];
	logic          byte_valid_q;
	logic [7:0]    init_byte_q;

	logic          req_fire;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	logic          wr_ok;
	logic          wr_refuse;
	logic          rd_ok;
	logic [3:0]    rd_n;
	logic [7:0]    rd_byte;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = cmd.req_ready;

	irmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	irmt_lookup #(
		.MAP_ENTRIES   (MAP_ENTRIES),
		.STORE_BYTES   (STORE_BYTES),
		.MAX_REG_BYTES (MAX_REG_BYTES)
	) u_lookup (
		.addr   (lk_addr_q),
		.result (lk)
	);

	irmt_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// decision taken in the lookup step
	always_comb begin
		wr_ok     = (op_q == OP_WRITE) && (len_q > 4'd1) && lk.hit && lk.writable &&
			((len_q - 4'd1) <= lk.width);
		wr_refuse = (op_q == OP_WRITE) && (len_q > 4'd1) && !wr_ok;
		rd_ok     = (op_q == OP_READ) && !(rrs_q && !rs_q) && lk.hit;
		rd_n      = (len_q < lk.width) ? len_q : lk.width;
	end

	assign ram_addr  = off_q + AW'(k_q);
	assign ram_wdata = wdata_q[k_q[2:0]*8 +: 8];
	assign rd_byte   = byte_valid_q ? ram_rdata : init_byte_q;

	always_comb begin
		stat          = '0;
		stat.req_fire = req_fire;
		stat.go_write = wr_ok;
		stat.go_read  = rd_ok && (rd_n != 4'd0);
		stat.last     = ((k_q + 4'd1) == n_q);
		stat.rsp_free = !rsp_valid_q || rsp.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rrs_q     <= 1'b0;
			cur_ptr_q <= 8'h00;
		end else begin
			if (cfg_we)
				rrs_q <= cfg_wdata;
			if (req_fire && req.operation == OP_WRITE && req.byte_count != 4'd0)
				cur_ptr_q <= req.pointer_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q      <= req.operation;
			len_q     <= req.byte_count;
			wdata_q   <= req.write_data;
			rs_q      <= req.repeated_start;
			lk_addr_q <= (req.operation == OP_READ) ? cur_ptr_q : req.pointer_byte;
			k_q       <= 4'd0;
			rdata_q   <= 64'h0;
		end
		if (cmd.look) begin
			off_q    <= lk.offset[AW-1:0];
			n_q      <= wr_ok ? (len_q - 4'd1) : rd_n;
			status_q <= wr_refuse ? STATUS_NACK : STATUS_ACK;
			rcount_q <= rd_ok ? rd_n : 4'd0;
		end
		if (cmd.wr)
			k_q <= k_q + 4'd1;
		if (cmd.rd_issue) begin
			byte_valid_q <= valid_q[ram_addr];
			init_byte_q  <= ResetImg[8'(ram_addr)];
		end
		if (cmd.rd_capt) begin
			rdata_q[k_q[2:0]*8 +: 8] <= rd_byte;
			k_q                      <= k_q + 4'd1;
		end
	end

	// a byte reads from the ram once written, from the reset image before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_BYTES; i++)
				valid_q[i] <= 1'b0;
		end else if (cmd.wr) begin
			valid_q[ram_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.done && stat.rsp_free)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.done && stat.rsp_free) begin
			rsp_status_q <= status_q;
			rsp_count_q  <= rcount_q;
			rsp_data_q   <= rdata_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.read_count = rsp_count_q;
	assign rsp.read_data  = rsp_data_q;

	a_wr_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (op_q == OP_WRITE) && (k_q < n_q))
		else $error("store write outside an accepted write transfer");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_capt |-> (op_q == OP_READ) && (k_q < n_q) && (n_q <= 4'd8))
		else $error("read byte beyond register width");

	a_done_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done && stat.rsp_free |=> rsp.valid)
		else $error("finished transfer not presented");

	a_nack_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> (rsp.read_count == 4'd0) && (rsp.read_data == 64'h0))
		else $error("refused write carries read data");

endmodule
